### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

### hw/rtl/adcl_pkg.sv
package adcl_pkg;

    // Widths of the directory state and of the ports.
    localparam int POS_W       = 6;
    localparam int IDX_W       = 5;
    localparam int SECTOR_W    = 6;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    // CRC-8 constants, MSB first.
    localparam logic [7:0] CRC_POLY = 8'h1D;
    localparam logic [7:0] CRC_INIT = 8'hC7;

    // Sector offset of the second directory.
    localparam logic [SECTOR_W-1:0] SECOND_SECTOR_OFFSET = 6'd16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_AID = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_DIR = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_BAD_CHECK = 2'd2
    } status_t;

    // One result beat.
    typedef struct packed {
        status_t             status;
        logic [SECTOR_W-1:0] sector;
        logic [7:0]          computed_crc;
    } result_t;

    // One byte through the CRC-8, eight shift steps unrolled.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### hw/rtl/adcl_if.sv
// Directory byte channel.
interface adcl_in_if;
    import adcl_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

// Lookup result channel.
interface adcl_out_if;
    import adcl_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [SECTOR_W-1:0] sector;
    logic [7:0]          computed_crc;

    modport source (output valid, output status, output sector, output computed_crc,
                    input ready);
    modport sink (input valid, input status, input sector, input computed_crc,
                  output ready);
endinterface

### hw/rtl/app_directory_crc_lookup.sv
// The result beat is registered: it becomes valid in the cycle after the last directory byte is taken.
// Throughput: one directory byte per cycle; a CRC-8 step and a 16-bit compare per byte.
// Only the closing byte waits, and only while a previous result is still unread.
// Reset: rst_n clears the directory state to its start, the registers to zero and
// the result register to empty, asynchronously.
module app_directory_crc_lookup #(
    parameter int FIRST_DIR_BYTES  = 32,
    parameter int SECOND_DIR_BYTES = 48
) (
    input  logic                            clk,
    input  logic                            rst_n,
    adcl_in_if.sink                         dir_bytes,
    adcl_out_if.source                      result,
    input  logic                            cfg_wr_en,
    input  logic [adcl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [adcl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import adcl_pkg::*;

    logic [CFG_DATA_W-1:0] search_aid_reg;
    logic                  second_dir_reg;
    result_t               result_next;
    logic                  result_load;
    logic                  out_busy;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_aid_reg <= '0;
            second_dir_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SEARCH_AID: search_aid_reg <= cfg_wdata;
                REG_SECOND_DIR: second_dir_reg <= cfg_wdata[0];
            endcase
        end
    end

    // Per-byte CRC, pairing and match tracking.
    adcl_dir_track #(
        .FIRST_DIR_BYTES  (FIRST_DIR_BYTES),
        .SECOND_DIR_BYTES (SECOND_DIR_BYTES)
    ) u_track (
        .clk              (clk),
        .rst_n            (rst_n),
        .dir_bytes        (dir_bytes),
        .search_aid       (search_aid_reg),
        .second_directory (second_dir_reg),
        .out_busy         (out_busy),
        .result_next      (result_next),
        .result_load      (result_load)
    );

    // Result register.
    adcl_out_reg u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (result_load),
        .result_next (result_next),
        .result      (result),
        .busy        (out_busy)
    );

endmodule

### hw/rtl/adcl_dir_track.sv
module adcl_dir_track #(
    parameter int FIRST_DIR_BYTES  = 32,
    parameter int SECOND_DIR_BYTES = 48
) (
    input  logic                           clk,
    input  logic                           rst_n,
    adcl_in_if.sink                        dir_bytes,
    input  logic [adcl_pkg::CFG_DATA_W-1:0] search_aid,
    input  logic                           second_directory,
    input  logic                           out_busy,
    output adcl_pkg::result_t              result_next,
    output logic                           result_load
);
    import adcl_pkg::*;

    localparam logic [POS_W:0] FIRST_LEN  = (POS_W+1)'(FIRST_DIR_BYTES);
    localparam logic [POS_W:0] SECOND_LEN = (POS_W+1)'(SECOND_DIR_BYTES);

    logic [POS_W-1:0] pos_reg;
    logic [7:0]       crc_reg;
    logic [7:0]       check_reg;
    logic [7:0]       high_reg;
    logic             seen_reg;
    logic [IDX_W-1:0] idx_reg;

    logic [POS_W:0]   dir_len;
    logic             last;
    logic             accept;
    logic [7:0]       crc_new;
    logic [7:0]       check_new;
    logic             pair_slot;
    logic             hit;
    logic             found;
    logic [IDX_W-1:0] found_idx;

    // The length in force now decides whether this byte closes the directory.
    assign dir_len = second_directory ? SECOND_LEN : FIRST_LEN;
    assign last    = ({1'b0, pos_reg} + (POS_W+1)'(1)) >= dir_len;

    // Bytes that close nothing never wait on the result register.
    assign dir_bytes.ready = !last || !out_busy;
    assign accept          = dir_bytes.valid && dir_bytes.ready;

    // Byte 0 is the stored check; later bytes feed the CRC.
    assign crc_new   = (pos_reg == '0) ? crc_reg : crc8_byte(crc_reg, dir_bytes.data_byte);
    assign check_new = (pos_reg == '0) ? dir_bytes.data_byte : check_reg;

    // Odd positions from three upward complete an identifier pair.
    assign pair_slot = pos_reg[0] && (pos_reg[POS_W-1:1] != '0);
    assign hit       = pair_slot && !seen_reg && ({high_reg, dir_bytes.data_byte} == search_aid);
    assign found     = seen_reg || hit;
    assign found_idx = seen_reg ? idx_reg : pos_reg[POS_W-1:1];

    // Result of the closing byte.
    always_comb
    begin
        result_next.computed_crc = crc_new;
        if (crc_new != check_new)
        begin
            result_next.status = STATUS_BAD_CHECK;
            result_next.sector = '0;
        end
        else if (found)
        begin
            result_next.status = STATUS_FOUND;
            result_next.sector = {1'b0, found_idx}
                               + (second_directory ? SECOND_SECTOR_OFFSET : '0);
        end
        else
        begin
            result_next.status = STATUS_NOT_FOUND;
            result_next.sector = '0;
        end
    end

    assign result_load = accept && last;

    // Directory state, restarted after the closing byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            crc_reg   <= CRC_INIT;
            check_reg <= '0;
            high_reg  <= '0;
            seen_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                pos_reg   <= '0;
                crc_reg   <= CRC_INIT;
                check_reg <= '0;
                high_reg  <= '0;
                seen_reg  <= 1'b0;
                idx_reg   <= '0;
            end
            else
            begin
                pos_reg   <= pos_reg + POS_W'(1);
                crc_reg   <= crc_new;
                check_reg <= check_new;
                if (!pos_reg[0] && (pos_reg != '0))
                begin
                    high_reg <= dir_bytes.data_byte;
                end
                if (hit)
                begin
                    seen_reg <= 1'b1;
                    idx_reg  <= pos_reg[POS_W-1:1];
                end
            end
        end
    end

endmodule

### hw/rtl/adcl_out_reg.sv
module adcl_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  adcl_pkg::result_t result_next,
    adcl_out_if.source        result,
    output logic              busy
);
    import adcl_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // A held beat that the sink does not take this cycle blocks a new one.
    assign busy = valid_reg && !result.ready;

    // Valid flag of the result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload of the result beat.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_next;
        end
    end

    assign result.valid        = valid_reg;
    assign result.status       = data_reg.status;
    assign result.sector       = data_reg.sector;
    assign result.computed_crc = data_reg.computed_crc;

endmodule

### hw/rtl/adcl_checker.sv
`include "assert_macros.svh"

module adcl_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [1:0]                    res_status,
    input logic [adcl_pkg::SECTOR_W-1:0] res_sector,
    input logic [7:0]                    res_crc
);
    import adcl_pkg::*;

    logic                         stalled;
    logic                         status_legal;
    logic                         miss_beat;
    logic [SECTOR_W+9:0]          payload;

    // Helper terms that keep the assertions short.
    assign stalled      = res_valid && !res_ready;
    assign payload      = {res_status, res_sector, res_crc};
    assign status_legal = (res_status == STATUS_FOUND)
                       || (res_status == STATUS_NOT_FOUND)
                       || (res_status == STATUS_BAD_CHECK);
    assign miss_beat    = res_valid && (res_status != STATUS_FOUND);

    // A stalled result beat stays offered.
    `ASSERT_NEXT(a_valid_hold, clk, rst_n, stalled, res_valid)

    // A stalled result beat keeps its payload.
    `ASSERT_NEXT(a_payload_hold, clk, rst_n, stalled, $stable(payload))

    // Only the three defined status codes appear.
    `ASSERT_IMPLIES(a_status_code, clk, rst_n, res_valid, status_legal)

    // Only a found entry carries a sector.
    `ASSERT_IMPLIES(a_sector_zero, clk, rst_n, miss_beat, res_sector == '0)

endmodule

bind app_directory_crc_lookup adcl_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_status (result.status),
    .res_sector (result.sector),
    .res_crc    (result.computed_crc)
);

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import adcl_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int FIRST_LEN        = 32;
    localparam int SECOND_LEN       = 48;
    localparam int TARGET_BYTES     = 1700;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 3000;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    adcl_in_if  dir_if();
    adcl_out_if res_if();

    app_directory_crc_lookup #(
        .FIRST_DIR_BYTES(FIRST_LEN),
        .SECOND_DIR_BYTES(SECOND_LEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .dir_bytes(dir_if),
        .result(res_if),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Bytes waiting to be sent and lookup results waiting to arrive.
    logic [7:0] pending_bytes [$];
    result_t    expected_results [$];

    // Stimulus knobs, owned by the stimulus process.
    int in_idle_pct   = 25;
    int out_idle_pct  = 25;
    int hold_requests = 0;

    // Bookkeeping.
    int error_count   = 0;
    int bytes_queued  = 0;
    int bytes_taken   = 0;
    int results_found = 0;
    int results_miss  = 0;
    int results_bad   = 0;
    int quiet_cycles  = 0;

    // Predictor copy of the registers and of the directory state.
    logic [15:0]         aid_cfg;
    bit                  mode_cfg;
    logic [POS_W-1:0]    dir_pos;
    logic [7:0]          run_crc;
    logic [7:0]          check_byte;
    logic [7:0]          pending_high;
    bit                  found_flag;
    logic [IDX_W-1:0]    found_entry;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        bit         msb;
        int         k;
        r = crc ^ b;
        for (k = 0; k < 8; k++)
        begin
            msb = r[7];
            r = r << 1;
            if (msb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    task automatic restart_directory();
        dir_pos      = '0;
        run_crc      = CRC_INIT;
        check_byte   = '0;
        pending_high = '0;
        found_flag   = 1'b0;
        found_entry  = '0;
    endtask

    // Advance the directory state by one byte; the closing byte yields a lookup result.
    task automatic predict_byte(input logic [7:0] b);
        int      dir_len;
        bit      closing;
        result_t res;
        dir_len = mode_cfg ? SECOND_LEN : FIRST_LEN;
        closing = (int'(dir_pos) + 1 >= dir_len);
        if (dir_pos == 0)
            check_byte = b;
        else
        begin
            run_crc = crc_step(run_crc, b);
            if (dir_pos >= 2)
            begin
                if (!dir_pos[0])
                    pending_high = b;
                else if (!found_flag && {pending_high, b} == aid_cfg)
                begin
                    found_flag  = 1'b1;
                    found_entry = dir_pos[POS_W-1:1];
                end
            end
        end
        if (!closing)
            dir_pos = dir_pos + 1'b1;
        else
        begin
            res.computed_crc = run_crc;
            if (run_crc != check_byte)
            begin
                res.status = STATUS_BAD_CHECK;
                res.sector = '0;
            end
            else if (found_flag)
            begin
                res.status = STATUS_FOUND;
                res.sector = {1'b0, found_entry} + (mode_cfg ? SECOND_SECTOR_OFFSET : '0);
            end
            else
            begin
                res.status = STATUS_NOT_FOUND;
                res.sector = '0;
            end
            expected_results.push_back(res);
            restart_directory();
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    // Sender: offers queued bytes, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_if.valid     <= 1'b0;
            dir_if.data_byte <= 8'h00;
        end
        else if (!dir_if.valid || dir_if.ready)
        begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= in_idle_pct)
            begin
                dir_if.valid     <= 1'b1;
                dir_if.data_byte <= pending_bytes.pop_front();
            end
            else
                dir_if.valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    int hold_left;
    int holds_served;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else if (holds_served != hold_requests)
        begin
            holds_served <= hold_requests;
            hold_left    <= LONG_HOLD_CYCLES;
            res_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end
        else
            res_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Monitor: checks each result beat, then feeds each accepted byte to the predictor.
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result: status %0d sector %0d crc 0x%02h",
                                              res_if.status, res_if.sector, res_if.computed_crc));
                else
                begin
                    want = expected_results.pop_front();
                    case (want.status)
                        STATUS_FOUND:     results_found++;
                        STATUS_NOT_FOUND: results_miss++;
                        default:          results_bad++;
                    endcase
                    if (res_if.status !== want.status)
                        report_mismatch($sformatf("status got %0d, expected %0d",
                                                  res_if.status, want.status));
                    if (res_if.sector !== want.sector)
                        report_mismatch($sformatf("sector got %0d, expected %0d",
                                                  res_if.sector, want.sector));
                    if (res_if.computed_crc !== want.computed_crc)
                        report_mismatch($sformatf("computed_crc got 0x%02h, expected 0x%02h",
                                                  res_if.computed_crc, want.computed_crc));
                end
            end
            if (dir_if.valid && dir_if.ready)
            begin
                bytes_taken++;
                predict_byte(dir_if.data_byte);
            end
        end
    end

    // Watchdog: ends the run if no beat moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (dir_if.valid && dir_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_random_bytes(input int count);
        int i;
        for (i = 0; i < count; i++)
            push_byte(8'($urandom_range(255)));
    endtask

    // Wait until every byte is taken and every result has come, then let the block settle.
    // The queues and the valid flag are looked at on the falling edge, once they have settled.
    task automatic drain();
        @(negedge clk);
        while (pending_bytes.size() != 0 || dir_if.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_SEARCH_AID)
            aid_cfg = value;
        else
            mode_cfg = value[0];
    endtask

    task automatic configure(input bit mode, input logic [15:0] aid);
        drain();
        write_reg(REG_SEARCH_AID, aid);
        write_reg(REG_SECOND_DIR, {15'b0, mode});
    endtask

    // Build one whole directory, placing the identifier at up to two entries.
    task automatic queue_directory(input bit mode, input logic [15:0] aid, input bit good_check,
                                   input int entry_a, input int entry_b, input fill_t fill);
        logic [7:0] dir_buf [0:63];
        logic [7:0] crc;
        int         len;
        int         i;
        len = mode ? SECOND_LEN : FIRST_LEN;
        for (i = 1; i < len; i++)
        begin
            case (fill)
                FILL_ZERO: dir_buf[i] = 8'h00;
                FILL_ONES: dir_buf[i] = 8'hFF;
                default:   dir_buf[i] = 8'($urandom_range(255));
            endcase
        end
        if (entry_a > 0)
        begin
            dir_buf[2 * entry_a]     = aid[15:8];
            dir_buf[2 * entry_a + 1] = aid[7:0];
        end
        if (entry_b > 0)
        begin
            dir_buf[2 * entry_b]     = aid[15:8];
            dir_buf[2 * entry_b + 1] = aid[7:0];
        end
        crc = CRC_INIT;
        for (i = 1; i < len; i++)
            crc = crc_step(crc, dir_buf[i]);
        dir_buf[0] = good_check ? crc : crc ^ 8'($urandom_range(1, 255));
        for (i = 0; i < len; i++)
            push_byte(dir_buf[i]);
    endtask

    task automatic queue_random_directory(input bit mode, input logic [15:0] aid);
        int entries;
        int r;
        int entry_a;
        int entry_b;
        entries = (mode ? SECOND_LEN : FIRST_LEN) / 2 - 1;
        r = $urandom_range(99);
        entry_a = (r < 60) ? $urandom_range(1, entries) : 0;
        entry_b = (r < 15) ? $urandom_range(1, entries) : 0;
        queue_directory(mode, aid, $urandom_range(99) < 75, entry_a, entry_b, FILL_RANDOM);
    endtask

    // Finish a directory left open by the previous phase, at the length now in force.
    task automatic close_partial(input bit mode);
        int len;
        len = mode ? SECOND_LEN : FIRST_LEN;
        if (dir_pos != 0)
            push_random_bytes((int'(dir_pos) + 1 >= len) ? 1 : len - int'(dir_pos));
    endtask

    initial
    begin : stimulus
        logic [15:0] aid;
        bit          mode;
        int          phase;
        int          dirs;
        int          r;
        int          i;

        aid_cfg  = '0;
        mode_cfg = 1'b0;
        restart_directory();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // All-zero and all-ones directories hit entry one at the identifier extremes.
        configure(1'b0, 16'h0000);
        queue_directory(1'b0, 16'h0000, 1'b1, 0, 0, FILL_ZERO);
        configure(1'b0, 16'hFFFF);
        queue_directory(1'b0, 16'hFFFF, 1'b1, 0, 0, FILL_ONES);
        // Bad check wins over a match.
        queue_directory(1'b0, 16'hFFFF, 1'b0, 0, 0, FILL_ONES);

        // Last entry, no match, then the second directory with its sector offset.
        aid = 16'($urandom_range(16'hFFFF));
        configure(1'b0, aid);
        queue_directory(1'b0, aid, 1'b1, FIRST_LEN / 2 - 1, 0, FILL_RANDOM);
        queue_directory(1'b0, aid, 1'b1, 0, 0, FILL_RANDOM);
        configure(1'b1, aid);
        queue_directory(1'b1, aid, 1'b1, SECOND_LEN / 2 - 1, 0, FILL_RANDOM);
        queue_directory(1'b1, aid, 1'b1, 9, 5, FILL_RANDOM);
        queue_directory(1'b1, aid, 1'b0, 1, 0, FILL_RANDOM);

        // Switch to the longer directory partway through a short one.
        configure(1'b0, aid);
        push_random_bytes(20);
        configure(1'b1, aid);
        push_random_bytes(SECOND_LEN - 20);

        // Switch to the short directory past its end: the next byte closes it unpaired.
        push_random_bytes(40);
        configure(1'b0, aid);
        push_random_bytes(1);

        // Change the identifier partway through a directory.
        push_random_bytes(10);
        configure(1'b0, ~aid);
        push_random_bytes(FIRST_LEN - 10);

        // Random phases, each with fresh register values, until the byte budget is used
        // and both pressure phases have run.
        phase = 0;
        while (bytes_queued < TARGET_BYTES || phase <= 7)
        begin
            mode = 1'($urandom_range(1));
            r = $urandom_range(9);
            aid = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(16'hFFFF));
            configure(mode, aid);
            if (phase == 3)
            begin
                // Long stretch with no idling on either side.
                in_idle_pct  <= 0;
                out_idle_pct <= 0;
                dirs = 10;
            end
            else if (phase == 7)
            begin
                // Receiver holds off while the sender streams, so the input stalls.
                in_idle_pct   <= 0;
                out_idle_pct  <= 25;
                hold_requests <= hold_requests + 1;
                dirs = 4;
            end
            else
            begin
                in_idle_pct  <= 25;
                out_idle_pct <= 25;
                dirs = $urandom_range(1, 3);
            end
            close_partial(mode);
            for (i = 0; i < dirs; i++)
                queue_random_directory(mode, aid);
            if ($urandom_range(99) < 15)
                push_random_bytes($urandom_range(1, (mode ? SECOND_LEN : FIRST_LEN) - 1));
            phase++;
        end

        drain();
        $display("Checked %0d lookup results (%0d found, %0d not found, %0d bad check)",
                 results_found + results_miss + results_bad, results_found, results_miss,
                 results_bad);
        $display("from %0d bytes over %0d random phases in both directory sizes",
                 bytes_taken, phase);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
